// ===== hdl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES = 4096;
  localparam int ENTRIES    = HEAP_BYTES / 8;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int HDR_W      = 14;                 // header word: size | used bit
  localparam int OFF_W      = HDR_W;              // byte offsets and chunk sizes
  localparam int NEED_W     = 17;                 // rounded request plus header
  localparam int REQ_W      = 16;
  localparam int ADDR_W     = 16;
  localparam int POFF_W     = 12;

  localparam logic [OFF_W-1:0] HEAP_LIMIT = OFF_W'(HEAP_BYTES);
  localparam logic [OFF_W-1:0] HDR_BYTES  = OFF_W'(8);
  localparam logic [OFF_W-1:0] MIN_CHUNK  = OFF_W'(16);

  // Operation kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADPTR  = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/first_fit_heap_allocator_top.sv =====
// Sequence (accept to result): allocate walks the chunk headers in S_ACHK, then S_ASPL on a split;
//   free walks in S_FCHK, then S_FMRG, plus S_FNXT when a next chunk exists; a rejected free
//   ends in S_FCHK; a null or out-of-heap free finishes from S_IDLE. At most HEAP_BYTES/16 headers.
// Throughput: one request at a time (busy while walking); the next
//   request is accepted in the cycle the result strobe out_valid shows; no receiver stall.
// Reset (rst_n low, synchronous) makes the whole heap one free chunk; no clearing pass.
`default_nettype none
module first_fit_heap_allocator_top
  import ffha_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_kind,
  input  wire logic [REQ_W-1:0]  in_req_size,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic              in_null_pointer,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [POFF_W-1:0]      out_payload_offset
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACHK = 3'd1;
  localparam logic [2:0] S_ASPL = 3'd2;
  localparam logic [2:0] S_FCHK = 3'd3;
  localparam logic [2:0] S_FMRG = 3'd4;
  localparam logic [2:0] S_FNXT = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [OFF_W-1:0]  extra_r, extra_nxt;
  logic [OFF_W-1:0]  prev_off_r, prev_off_nxt;
  logic [OFF_W-1:0]  prev_size_r, prev_size_nxt;
  logic              prev_free_r, prev_free_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [OFF_W-1:0]  base_r, base_nxt;
  logic [OFF_W-1:0]  msize_r, msize_nxt;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [POFF_W-1:0] out_poff_r;

  // Header memory and its read path
  logic [HDR_W-1:0] mem [ENTRIES];
  logic [HDR_W-1:0] rd_data_r, fwd_data_r;
  logic             fwd_r, init0_r, w0_r;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [HDR_W-1:0] wr_data;
  logic             wr_en;
  logic [HDR_W-1:0] hdr;
  logic [OFF_W-1:0] hdr_size;
  logic             hdr_used;

  // Finish signals
  logic              fin;
  logic [1:0]        fin_status;
  logic [POFF_W-1:0] fin_poff;

  logic              accept;
  logic [NEED_W-1:0] need_calc;
  logic [OFF_W-1:0]  sum;
  logic [OFF_W-1:0]  pay_off;
  logic [OFF_W-1:0]  nxt_off;
  logic [OFF_W-1:0]  split_off;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r  <= mem[rd_idx];
    fwd_data_r <= wr_data;
  end

  // Forwarding of a same-cycle write, and the reset image of entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r   <= 1'b0;
      init0_r <= 1'b0;
      w0_r    <= 1'b0;
    end else begin
      fwd_r   <= wr_en && (wr_idx == rd_idx);
      init0_r <= (rd_idx == '0) && !w0_r;
      if (wr_en && (wr_idx == '0)) begin
        w0_r <= 1'b1;
      end
    end
  end

  always_comb begin
    if (fwd_r) begin
      hdr = fwd_data_r;
    end else if (init0_r) begin
      hdr = HDR_W'(HEAP_BYTES);
    end else begin
      hdr = rd_data_r;
    end
  end

  assign hdr_size = {hdr[HDR_W-1:3], 3'b000};
  assign hdr_used = hdr[0];

  // Rounded request: multiple of 8 plus header, at least MIN_CHUNK
  always_comb begin
    need_calc = ((NEED_W'(in_req_size) + NEED_W'(7)) & ~NEED_W'(7)) + NEED_W'(HDR_BYTES);
    if (need_calc < NEED_W'(MIN_CHUNK)) begin
      need_calc = NEED_W'(MIN_CHUNK);
    end
  end

  assign sum       = cur_r + hdr_size;
  assign pay_off   = cur_r + HDR_BYTES;
  assign nxt_off   = base_r + msize_r;
  assign split_off = cur_r + need_r[OFF_W-1:0];

  // Walk and update sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    extra_nxt     = extra_r;
    prev_off_nxt  = prev_off_r;
    prev_size_nxt = prev_size_r;
    prev_free_nxt = prev_free_r;
    have_prev_nxt = have_prev_r;
    base_nxt      = base_r;
    msize_nxt     = msize_r;
    rd_idx        = cur_r[IDX_W+2:3];
    wr_en         = 1'b0;
    wr_idx        = cur_r[IDX_W+2:3];
    wr_data       = '0;
    fin           = 1'b0;
    fin_status    = ST_OK;
    fin_poff      = '0;

    case (state_r)
      S_IDLE: begin
        rd_idx = '0;
        if (accept) begin
          cur_nxt       = '0;
          need_nxt      = need_calc;
          addr_nxt      = in_address;
          have_prev_nxt = 1'b0;
          if (in_kind == KIND_ALLOC) begin
            state_nxt = S_ACHK;
          end else if (in_null_pointer) begin
            fin = 1'b1;
          end else if (in_address >= ADDR_W'(HEAP_BYTES)) begin
            fin        = 1'b1;
            fin_status = ST_BADPTR;
          end else begin
            state_nxt = S_FCHK;
          end
        end
      end

      // Allocate: check one chunk per cycle
      S_ACHK: begin
        if (hdr_size == '0) begin
          fin        = 1'b1;
          fin_status = ST_NOSPACE;
        end else if (!hdr_used && (NEED_W'(hdr_size) >= need_r)) begin
          extra_nxt = hdr_size - need_r[OFF_W-1:0];
          wr_en     = 1'b1;
          if (extra_nxt >= MIN_CHUNK) begin
            wr_data   = need_r[HDR_W-1:0] | HDR_W'(1);
            state_nxt = S_ASPL;
          end else begin
            wr_data  = hdr_size | HDR_W'(1);
            fin      = 1'b1;
            fin_poff = pay_off[POFF_W-1:0];
          end
        end else if (sum >= HEAP_LIMIT) begin
          fin        = 1'b1;
          fin_status = ST_NOSPACE;
        end else begin
          cur_nxt = sum;
          rd_idx  = sum[IDX_W+2:3];
        end
      end

      // Allocate: write the split-off remainder
      S_ASPL: begin
        wr_en    = 1'b1;
        wr_idx   = split_off[IDX_W+2:3];
        wr_data  = extra_r;
        fin      = 1'b1;
        fin_poff = pay_off[POFF_W-1:0];
      end

      // Free: look for the chunk whose payload matches
      S_FCHK: begin
        if (hdr_size == '0) begin
          fin        = 1'b1;
          fin_status = ST_BADPTR;
        end else if ({1'b0, addr_r} == (ADDR_W+1)'(pay_off)) begin
          if (!hdr_used) begin
            fin        = 1'b1;
            fin_status = ST_BADPTR;
          end else begin
            wr_en   = 1'b1;
            wr_data = hdr_size;
            if (have_prev_r && prev_free_r) begin
              base_nxt  = prev_off_r;
              msize_nxt = prev_size_r + hdr_size;
            end else begin
              base_nxt  = cur_r;
              msize_nxt = hdr_size;
            end
            state_nxt = S_FMRG;
          end
        end else if (sum >= HEAP_LIMIT) begin
          fin        = 1'b1;
          fin_status = ST_BADPTR;
        end else begin
          prev_off_nxt  = cur_r;
          prev_size_nxt = hdr_size;
          prev_free_nxt = !hdr_used;
          have_prev_nxt = 1'b1;
          cur_nxt       = sum;
          rd_idx        = sum[IDX_W+2:3];
        end
      end

      // Free: merge into the previous chunk if it is free, fetch the next header if one exists
      S_FMRG: begin
        if (base_r != cur_r) begin
          wr_en   = 1'b1;
          wr_idx  = base_r[IDX_W+2:3];
          wr_data = msize_r;
        end
        if (nxt_off < HEAP_LIMIT) begin
          rd_idx    = nxt_off[IDX_W+2:3];
          state_nxt = S_FNXT;
        end else begin
          fin = 1'b1;
        end
      end

      // Free: absorb a free next chunk
      S_FNXT: begin
        if (!hdr_used) begin
          wr_en   = 1'b1;
          wr_idx  = base_r[IDX_W+2:3];
          wr_data = msize_r + hdr_size;
        end
        fin = 1'b1;
      end

      default: begin
        fin        = 1'b1;
        fin_status = ST_BADPTR;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    need_r      <= need_nxt;
    addr_r      <= addr_nxt;
    extra_r     <= extra_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_size_r <= prev_size_nxt;
    prev_free_r <= prev_free_nxt;
    have_prev_r <= have_prev_nxt;
    base_r      <= base_nxt;
    msize_r     <= msize_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_poff_r   <= fin_poff;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_poff_r;

endmodule
`default_nettype wire

// ===== test/ffha_checker.sv =====
`default_nettype none
module ffha_checker
  import ffha_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic              in_kind,
  input  wire logic [REQ_W-1:0]  in_req_size,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic              in_null_pointer,
  input  wire logic              out_valid,
  input  wire logic [1:0]        out_status,
  input  wire logic [POFF_W-1:0] out_payload_offset,
  output int                     n_mismatch,
  output int                     pending,
  output int                     n_grant,
  output int                     n_nospace,
  output int                     n_reject
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USED = 1;

  typedef struct packed {
    logic [1:0]        status;
    logic [POFF_W-1:0] offset;
  } grant_t;

  // Shadow heap: one header word per 8-byte slot
  logic [HDR_W-1:0] heap_hdr [ENTRIES];
  grant_t           awaited [$];
  int               errs, grants, fulls, rejects;

  function automatic int hdr_len(input int off);
    return int'(heap_hdr[(off >> 3) % ENTRIES]) & ~7;
  endfunction

  function automatic void hdr_put(input int off, input int val);
    heap_hdr[(off >> 3) % ENTRIES] = HDR_W'(val);
  endfunction

  // Merge a freshly freed chunk with free neighbors on both sides
  function automatic void coalesce(input int cur);
    int walk, prev, size, next;
    bit have_prev;
    walk = 0;
    prev = 0;
    have_prev = 0;
    if (cur != 0) begin
      while (walk < HEAP_BYTES) begin
        size = hdr_len(walk);
        if (size == 0) break;
        next = walk + size;
        if (next == cur) begin
          prev = walk;
          have_prev = 1;
          break;
        end
        if (next > cur) break;
        walk = next;
      end
    end
    if (have_prev && heap_hdr[(prev >> 3) % ENTRIES][0] == 1'b0) begin
      hdr_put(prev, hdr_len(prev) + hdr_len(cur));
      cur = prev;
    end
    size = hdr_len(cur);
    next = cur + size;
    if (next < HEAP_BYTES && heap_hdr[(next >> 3) % ENTRIES][0] == 1'b0)
      hdr_put(cur, size + hdr_len(next));
  endfunction

  // First-fit walk; split when the remainder can hold a minimum chunk
  function automatic grant_t heap_alloc(input logic [REQ_W-1:0] req);
    int need, cur, size, extra;
    logic [HDR_W-1:0] h;
    grant_t g;
    need = ((int'(req) + 7) & ~7) + int'(HDR_BYTES);
    if (need < int'(MIN_CHUNK)) need = int'(MIN_CHUNK);
    cur = 0;
    while (cur < HEAP_BYTES) begin
      h = heap_hdr[(cur >> 3) % ENTRIES];
      size = int'(h) & ~7;
      if (size == 0) break;
      if (h[0] == 1'b0 && size >= need) begin
        extra = size - need;
        if (extra >= int'(MIN_CHUNK)) begin
          hdr_put(cur, need | USED);
          hdr_put(cur + need, extra);
        end else begin
          hdr_put(cur, size | USED);
        end
        g.status = ST_OK;
        g.offset = POFF_W'(cur + int'(HDR_BYTES));
        return g;
      end
      cur += size;
    end
    g.status = ST_NOSPACE;
    g.offset = '0;
    return g;
  endfunction

  // Find the chunk whose payload starts at addr; reject anything else
  function automatic logic [1:0] heap_release(input logic [ADDR_W-1:0] addr);
    int cur, size;
    logic [HDR_W-1:0] h;
    if (int'(addr) >= HEAP_BYTES) return ST_BADPTR;
    cur = 0;
    while (cur < HEAP_BYTES) begin
      h = heap_hdr[(cur >> 3) % ENTRIES];
      size = int'(h) & ~7;
      if (size == 0) return ST_BADPTR;
      if (int'(addr) == cur + int'(HDR_BYTES)) begin
        if (h[0] == 1'b0) return ST_BADPTR;   // already free
        hdr_put(cur, size);
        coalesce(cur);
        return ST_OK;
      end
      cur += size;
    end
    return ST_BADPTR;
  endfunction

  always @(posedge clk) begin
    grant_t want, got;
    if (!rst_n) begin
      foreach (heap_hdr[i]) heap_hdr[i] = '0;
      heap_hdr[0] = HDR_W'(HEAP_BYTES);
      awaited.delete();
    end else begin
      // accepted request: predict its result
      if (start && !busy) begin
        if (in_kind == KIND_ALLOC) begin
          want = heap_alloc(in_req_size);
        end else if (in_null_pointer) begin
          want.status = ST_OK;
          want.offset = '0;
        end else begin
          want.status = heap_release(in_address);
          want.offset = '0;
        end
        awaited.push_back(want);
      end
      // result strobe: compare with oldest prediction
      if (out_valid) begin
        got.status = out_status;
        got.offset = out_payload_offset;
        if (awaited.size() == 0) begin
          $error("unexpected result: status %0d offset %0d", got.status, got.offset);
          errs++;
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.offset !== want.offset) begin
            $error("payload_offset: expected %0d, got %0d", want.offset, got.offset);
            errs++;
          end
          case (want.status)
            ST_OK:      if (want.offset != '0) grants++;
            ST_NOSPACE: fulls++;
            default:    rejects++;
          endcase
        end
      end
    end
    n_mismatch <= errs;
    pending    <= awaited.size();
    n_grant    <= grants;
    n_nospace  <= fulls;
    n_reject   <= rejects;
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int IDLE_LIMIT   = 4000;   // longest walk plus longest gap, several times
  localparam int DRAIN_CYCLES = 600;
  localparam int STALE_MAX    = 32;

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              in_kind         = KIND_ALLOC;
  logic [REQ_W-1:0]  in_req_size     = '0;
  logic [ADDR_W-1:0] in_address      = '0;
  logic              in_null_pointer = 1'b0;
  logic              busy, out_valid;
  logic [1:0]        out_status;
  logic [POFF_W-1:0] out_payload_offset;

  int n_mismatch, pending, n_grant, n_nospace, n_reject;
  int sent, idle_cycles, peak_live;
  bit no_idle;
  logic last_kind = KIND_ALLOC;

  // payloads currently held, and ones given back (for double-free tries)
  int live_ptrs [$];
  int stale_ptrs [$];

  first_fit_heap_allocator_top dut (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_req_size, .in_address, .in_null_pointer,
    .out_valid, .out_status, .out_payload_offset
  );

  ffha_checker chk (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_req_size, .in_address, .in_null_pointer,
    .out_valid, .out_status, .out_payload_offset,
    .n_mismatch, .pending, .n_grant, .n_nospace, .n_reject
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // track granted payloads so frees can target real chunks
  always @(posedge clk) begin
    int k;
    if (rst_n && start && !busy) last_kind <= in_kind;
    if (rst_n && out_valid && last_kind == KIND_ALLOC && out_status == ST_OK) begin
      live_ptrs.push_back(int'(out_payload_offset));
      if (live_ptrs.size() > peak_live) peak_live = live_ptrs.size();
      k = 0;
      while (k < stale_ptrs.size()) begin
        if (stale_ptrs[k] == int'(out_payload_offset)) stale_ptrs.delete(k);
        else k++;
      end
    end
  end

  // watchdog: no request and no result for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drive one request after a random gap, hold until accepted
  task automatic send(input logic k, input logic [REQ_W-1:0] r,
                      input logic [ADDR_W-1:0] a, input logic np);
    int gap, roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 20);
    else gap = $urandom_range(30, 100);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= k;
    in_req_size     <= r;
    in_address      <= a;
    in_null_pointer <= np;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    int n, roll, sel, idx, alloc_pct;
    logic [REQ_W-1:0] sz;
    logic [ADDR_W-1:0] addr;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: whole-heap grant, full heap, null and double free
    send(KIND_ALLOC, 16'd4088, 16'd0, 1'b0);
    send(KIND_ALLOC, 16'd0, 16'd0, 1'b0);
    send(KIND_FREE, 16'd0, 16'd8, 1'b1);
    send(KIND_FREE, 16'd0, 16'd8, 1'b0);
    send(KIND_FREE, 16'd0, 16'd8, 1'b0);
    // minimum chunks, rounding, split, exact fit at heap end
    send(KIND_ALLOC, 16'd0, 16'hFFFF, 1'b1);
    send(KIND_ALLOC, 16'd1, 16'd0, 1'b0);
    send(KIND_ALLOC, 16'd9, 16'd0, 1'b0);
    send(KIND_ALLOC, 16'd4000, 16'd0, 1'b0);
    send(KIND_ALLOC, 16'd20, 16'd0, 1'b0);
    // frees: isolated, merge forward, last chunk, merge forward again
    send(KIND_FREE, 16'd0, 16'd24, 1'b0);
    send(KIND_FREE, 16'd0, 16'd8, 1'b0);
    send(KIND_FREE, 16'd0, 16'd4072, 1'b0);
    send(KIND_FREE, 16'd0, 16'd64, 1'b0);
    // bad pointers: inside chunk, at/over heap end, max, zero, misaligned; oversized alloc
    send(KIND_FREE, 16'hFFFF, 16'd4095, 1'b0);
    send(KIND_FREE, 16'd0, 16'd4096, 1'b0);
    send(KIND_FREE, 16'd0, 16'hFFFF, 1'b0);
    send(KIND_FREE, 16'd0, 16'd0, 1'b0);
    send(KIND_FREE, 16'd0, 16'd13, 1'b0);
    send(KIND_ALLOC, 16'hFFFF, 16'd0, 1'b0);
    // merge with both neighbors back to one chunk
    send(KIND_FREE, 16'd0, 16'd40, 1'b0);
    send(KIND_ALLOC, 16'd4081, 16'd0, 1'b0);
    send(KIND_FREE, 16'd0, 16'd8, 1'b0);
    // remainder too small to split
    send(KIND_ALLOC, 16'd4078, 16'd0, 1'b0);
    send(KIND_FREE, 16'd0, 16'd8, 1'b0);

    live_ptrs.delete();
    stale_ptrs.delete();

    // random: mostly real alloc/free traffic, some bad and null frees
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (live_ptrs.size() < 8) alloc_pct = 70;
      else if (live_ptrs.size() > 40) alloc_pct = 30;
      else alloc_pct = 50;
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) sz = REQ_W'($urandom_range(0, 64));
        else if (sel < 85) sz = REQ_W'($urandom_range(65, 512));
        else if (sel < 95) sz = REQ_W'($urandom_range(513, 4096));
        else sz = REQ_W'($urandom_range(0, 65535));
        send(KIND_ALLOC, sz, ADDR_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end else begin
        sel = $urandom_range(0, 99);
        sz = REQ_W'($urandom_range(0, 65535));
        if (sel < 70 && live_ptrs.size() > 0) begin
          idx = $urandom_range(0, live_ptrs.size() - 1);
          addr = ADDR_W'(live_ptrs[idx]);
          live_ptrs.delete(idx);
          stale_ptrs.push_back(int'(addr));
          if (stale_ptrs.size() > STALE_MAX) void'(stale_ptrs.pop_front());
          send(KIND_FREE, sz, addr, 1'b0);
        end else if (sel < 80 && stale_ptrs.size() > 0) begin
          idx = $urandom_range(0, stale_ptrs.size() - 1);
          send(KIND_FREE, sz, ADDR_W'(stale_ptrs[idx]), 1'b0);
        end else if (sel < 88) begin
          send(KIND_FREE, sz, ADDR_W'($urandom_range(0, 65535)), 1'b1);
        end else begin
          idx = $urandom_range(0, 2);
          if (idx == 0) addr = ADDR_W'($urandom_range(0, 65535));
          else if (idx == 1) addr = ADDR_W'($urandom_range(4096, 65535));
          else if (live_ptrs.size() > 0)
            addr = ADDR_W'(live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]
                           + $urandom_range(1, 15) - 8);
          else addr = ADDR_W'($urandom_range(0, 4095));
          send(KIND_FREE, sz, addr, 1'b0);
        end
      end
    end
    start <= 1'b0;

    // drain: wait for outstanding result, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d grants, %0d out-of-space, %0d rejected frees",
             sent, n_grant, n_nospace, n_reject);
    $display("Peak of %0d payloads held at once", peak_live);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/ffha_pkg.sv
hdl/first_fit_heap_allocator_top.sv
test/ffha_checker.sv
test/tb.sv
